/* design/ppmd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared types, constants and the control store of the prefix match engine.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  // Default sizes of the symbol store
  localparam int MAX_TIPS_DEF    = 64;
  localparam int MAX_SLOTS_DEF   = 16;
  localparam int MAX_SYMBOLS_DEF = 16;

  // Field widths fixed by the interface
  localparam int OP_W     = 1;
  localparam int TIP_W    = 6;
  localparam int SLOT_W   = 4;
  localparam int POS_W    = 4;
  localparam int SYM_W    = 8;
  localparam int DIST_W   = 9;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [SYM_W-1:0] UNEDITED = 8'h30;
  localparam int DIST_MAX = 511;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BARCODES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS  = 1'b1;

  // Microprogram steps
  typedef logic [2:0] step_t;
  localparam step_t STEP_FETCH = 3'd0;
  localparam step_t STEP_START = 3'd1;
  localparam step_t STEP_READ  = 3'd2;
  localparam step_t STEP_LOOP  = 3'd3;
  localparam step_t STEP_OUT   = 3'd4;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_QUERY,
    COND_SKIP,
    COND_MORE,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    logic  clr;
    logic  rd;
    logic  acc;
    logic  inc;
    logic  out_ld;
    cond_e cond;
    step_t jmp;
    step_t nxt;
  } ctl_t;

  typedef struct packed {
    logic query;
    logic skip;
    logic more;
    logic out_free;
  } sts_t;

  // Control store: one word per step
  function automatic ctl_t ctl_rom(input step_t step);
    ctl_t w;
    w = '0;
    unique case (step)
      STEP_FETCH: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_QUERY;
        w.jmp    = STEP_START;
        w.nxt    = STEP_FETCH;
      end
      STEP_START: begin
        w.clr  = 1'b1;
        w.cond = COND_SKIP;
        w.jmp  = STEP_OUT;
        w.nxt  = STEP_READ;
      end
      STEP_READ: begin
        w.rd   = 1'b1;
        w.inc  = 1'b1;
        w.cond = COND_ALWAYS;
        w.jmp  = STEP_LOOP;
        w.nxt  = STEP_LOOP;
      end
      STEP_LOOP: begin
        w.rd   = 1'b1;
        w.acc  = 1'b1;
        w.inc  = 1'b1;
        w.cond = COND_MORE;
        w.jmp  = STEP_LOOP;
        w.nxt  = STEP_OUT;
      end
      STEP_OUT: begin
        w.out_ld = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.jmp    = STEP_FETCH;
        w.nxt    = STEP_OUT;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.jmp  = STEP_FETCH;
        w.nxt  = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* design/ppmd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppmd_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ppmd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

/* design/ppmd_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppmd_seq
// Step counter and control store lookup with conditional jumps.
// ----------------------------------------------------------------------------
module ppmd_seq
  import ppmd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  step_t step_q, step_d;
  logic  taken;

  assign ctl_o = ctl_rom(step_q);

  always_comb begin
    unique case (ctl_o.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_QUERY:    taken = sts_i.query;
      COND_SKIP:     taken = sts_i.skip;
      COND_MORE:     taken = sts_i.more;
      COND_OUT_FREE: taken = sts_i.out_free;
      default:       taken = 1'b1;
    endcase
    step_d = taken ? ctl_o.jmp : ctl_o.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

/* design/ppmd_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppmd_dp
// Symbol lanes, row compare, prefix count and accumulator.
// ----------------------------------------------------------------------------
module ppmd_dp
  import ppmd_pkg::*;
#(
  parameter int MaxTips    = MAX_TIPS_DEF,
  parameter int MaxSlots   = MAX_SLOTS_DEF,
  parameter int MaxSymbols = MAX_SYMBOLS_DEF,
  localparam int CntW = $clog2(MaxSlots + 1),
  localparam int PfxW = $clog2(MaxSymbols + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctl_t              ctl_i,
  input  wire logic              ld_en_i,
  input  wire logic              cap_i,
  input  wire logic [TIP_W-1:0]  tip_i,
  input  wire logic [SLOT_W-1:0] slot_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [TIP_W-1:0]  partner_tip_i,
  input  wire logic [CntW-1:0]   nb_i,
  input  wire logic [PfxW-1:0]   ns_i,
  output logic                   skip_o,
  output logic                   more_o,
  output logic [DIST_W-1:0]      distance_o
);

  localparam int Rows = MaxTips * MaxSlots;
  localparam int RowW = $clog2(Rows);
  localparam int AccW = $clog2(MaxSlots * MaxSymbols + 1);

  logic [TIP_W-1:0] tip_q, partner_q;
  logic [CntW-1:0]  slot_q;
  logic [AccW-1:0]  acc_q;
  logic             ld_ok, re;
  logic [RowW-1:0]  wrow, row_a, row_b;
  logic [SYM_W-1:0] sym_a [MaxSymbols];
  logic [SYM_W-1:0] sym_b [MaxSymbols];
  logic             run, hit;
  logic [PfxW-1:0]  pfx;

  assign ld_ok = ld_en_i && (32'(tip_i) < MaxTips) && (32'(slot_i) < MaxSlots)
              && (32'(position_i) < MaxSymbols);
  assign wrow  = RowW'(32'(tip_i) * 32'(MaxSlots) + 32'(slot_i));
  assign row_a = RowW'(32'(tip_q) * 32'(MaxSlots) + 32'(slot_q));
  assign row_b = RowW'(32'(partner_q) * 32'(MaxSlots) + 32'(slot_q));

  assign more_o = slot_q < nb_i;
  assign skip_o = (nb_i == '0) || (32'(tip_q) >= MaxTips) || (32'(partner_q) >= MaxTips);
  assign re     = ctl_i.rd && more_o;

  // One lane per symbol position, a whole barcode row read per cycle
  for (genvar p = 0; p < MaxSymbols; p++) begin : g_lane
    ppmd_ram #(
      .Width(SYM_W),
      .Depth(Rows)
    ) u_ram (
      .clk_i    (clk_i),
      .we_i     (ld_ok && (32'(position_i) == p)),
      .waddr_i  (wrow),
      .wdata_i  (symbol_i),
      .re_i     (re),
      .raddr_a_i(row_a),
      .raddr_b_i(row_b),
      .rdata_a_o(sym_a[p]),
      .rdata_b_o(sym_b[p])
    );
  end

  // Count matching symbols from position zero up to the first break
  always_comb begin
    run = 1'b1;
    hit = 1'b0;
    pfx = '0;
    for (int p = 0; p < MaxSymbols; p++) begin
      hit = (sym_a[p] == sym_b[p]) && (sym_a[p] != UNEDITED) && (p < 32'(ns_i));
      run = run & hit;
      pfx = pfx + PfxW'(run);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      tip_q     <= tip_i;
      partner_q <= partner_tip_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctl_i.clr) begin
        slot_q <= '0;
        acc_q  <= '0;
      end else begin
        if (ctl_i.inc && more_o) begin
          slot_q <= slot_q + CntW'(1);
        end
        if (ctl_i.acc) begin
          acc_q <= acc_q + AccW'(pfx);
        end
      end
    end
  end

  assign distance_o = (32'(acc_q) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(acc_q);

endmodule
`default_nettype wire

/* design/pairwise_prefix_match_distance.sv */
`default_nettype none
// Load beat: accepted in the fetch step, writes one symbol, no result.
// Query beat: accepted in the fetch step, then runs the start, read, loop and out steps
//   (start jumps to out when nb = barcodes in use is zero); the next beat is accepted
//   the cycle after the result is registered, and out waits while a result sits stalled.
// The per-query loop is set by one barcode row read per cycle from the lane memories.
// Reset: registers return to 16, sequencer to fetch, output empty; store left as is.
// ----------------------------------------------------------------------------
// pairwise_prefix_match_distance
// Stores lineage barcodes and returns the summed shared-prefix length of a
// tip pair, driven by a small microprogrammed sequencer.
// ----------------------------------------------------------------------------
module pairwise_prefix_match_distance
  import ppmd_pkg::*;
#(
  parameter int MaxTips    = MAX_TIPS_DEF,
  parameter int MaxSlots   = MAX_SLOTS_DEF,
  parameter int MaxSymbols = MAX_SYMBOLS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input beats
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OP_W-1:0]      op_i,
  input  wire logic [TIP_W-1:0]     tip_i,
  input  wire logic [SLOT_W-1:0]    slot_i,
  input  wire logic [POS_W-1:0]     position_i,
  input  wire logic [SYM_W-1:0]     symbol_i,
  input  wire logic [TIP_W-1:0]     partner_tip_i,
  // result beats
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DIST_W-1:0]         distance_o,
  // register writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CntW = $clog2(MaxSlots + 1);
  localparam int PfxW = $clog2(MaxSymbols + 1);

  ctl_t ctl;
  sts_t sts;

  logic             in_acc, ld_en, query;
  logic [CFG_W-1:0] barcodes_q, symbols_q;
  logic [CntW-1:0]  nb;
  logic [PfxW-1:0]  ns;
  logic             skip, more;
  logic [DIST_W-1:0] dp_distance;
  logic             out_valid_q, out_valid_d, out_free;
  logic [DIST_W-1:0] dist_q;

  // Input side: beats are taken only in the fetch step
  assign in_stall_o = !ctl.in_rdy;
  assign in_acc     = in_valid_i && ctl.in_rdy;
  assign ld_en      = in_acc && (op_i == OP_LOAD);
  assign query      = in_acc && (op_i == OP_QUERY);

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      barcodes_q <= CFG_RESET;
      symbols_q  <= CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BARCODES: barcodes_q <= cfg_data_i;
        REG_SYMBOLS:  symbols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the register values to the store dimensions
  assign nb = (32'(barcodes_q) > MaxSlots)   ? CntW'(MaxSlots)   : CntW'(barcodes_q);
  assign ns = (32'(symbols_q)  > MaxSymbols) ? PfxW'(MaxSymbols) : PfxW'(symbols_q);

  // Output register frees the datapath while a result beat waits
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts.query    = query;
  assign sts.skip     = skip;
  assign sts.more     = more;
  assign sts.out_free = out_free;

  ppmd_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .ctl_o (ctl)
  );

  ppmd_dp #(
    .MaxTips   (MaxTips),
    .MaxSlots  (MaxSlots),
    .MaxSymbols(MaxSymbols)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .ld_en_i      (ld_en),
    .cap_i        (query),
    .tip_i        (tip_i),
    .slot_i       (slot_i),
    .position_i   (position_i),
    .symbol_i     (symbol_i),
    .partner_tip_i(partner_tip_i),
    .nb_i         (nb),
    .ns_i         (ns),
    .skip_o       (skip),
    .more_o       (more),
    .distance_o   (dp_distance)
  );

  // Load the result when the out step finds the register free, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.out_ld && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_ld && out_free) begin
      dist_q <= dp_distance;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

endmodule
`default_nettype wire
